/* sv/sha256_pkg.sv */
`default_nettype none

package sha256_pkg;

    typedef logic [31:0] word_t;

    // Initial hash value, H0 first.
    localparam word_t IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants, one per compression round.
    localparam word_t K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [5:0] LEN_POS       = 6'd56;
    localparam logic [5:0] LAST_POS      = 6'd63;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD_MARK,
        ST_PAD_FILL,
        ST_OUT
    } state_t;

    // Source of the byte shifted into the block buffer.
    typedef enum logic [1:0] {
        BYTE_IN,
        BYTE_MARK,
        BYTE_ZERO,
        BYTE_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      shift_en;
        byte_sel_t byte_sel;
        logic      count_inc;
        logic      init_work;
        logic      round_en;
        logic [5:0] round_idx;
        logic      fold;
        logic      restore;
        logic [2:0] out_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
    } dp_sts_t;

    function automatic word_t round_sum_a(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t round_sum_e(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t sched_mix_w1(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t sched_mix_w14(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

/* sv/sha256_datapath.sv */
`default_nettype none

module sha256_datapath import sha256_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic [7:0] data_byte,
    input  wire dp_cmd_t cmd,
    output dp_sts_t      sts,
    output word_t        digest_word
);

    // The block buffer doubles as the 16-word message schedule window.
    logic [511:0] blk_reg;
    word_t        work_reg [8];
    word_t        hash_reg [8];
    logic [5:0]   pos_reg;
    logic [60:0]  count_reg;

    logic [63:0]  len_bits;
    logic [63:0]  len_shift;
    logic [7:0]   byte_mux;
    word_t        w0, w1, w9, w14, w_new;
    word_t        t1, t2;

    // Byte selection: message byte, padding mark, zero or a length byte.
    always_comb begin
        len_bits  = {count_reg, 3'b000};
        len_shift = len_bits >> {~pos_reg[2:0], 3'b000};
        unique case (cmd.byte_sel)
            BYTE_IN:   byte_mux = data_byte;
            BYTE_MARK: byte_mux = PAD_MARK;
            BYTE_ZERO: byte_mux = 8'h00;
            BYTE_LEN:  byte_mux = len_shift[7:0];
            default:   byte_mux = 8'h00;
        endcase
    end

    // One compression round and the next schedule word.
    always_comb begin
        w0    = blk_reg[511:480];
        w1    = blk_reg[479:448];
        w9    = blk_reg[223:192];
        w14   = blk_reg[63:32];
        w_new = w0 + sched_mix_w1(w1) + w9 + sched_mix_w14(w14);
        t1    = work_reg[7] + round_sum_e(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + K_TABLE[cmd.round_idx] + w0;
        t2    = round_sum_a(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));
    end

    // Block buffer: bytes enter at the bottom, words leave at the top.
    always_ff @(posedge aclk) begin
        if (cmd.shift_en) begin
            blk_reg <= {blk_reg[503:0], byte_mux};
        end else if (cmd.round_en) begin
            blk_reg <= {blk_reg[479:0], w_new};
        end
    end

    // Working variables a to h.
    always_ff @(posedge aclk) begin
        if (cmd.init_work) begin
            work_reg <= hash_reg;
        end else if (cmd.round_en) begin
            work_reg[0] <= t1 + t2;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= work_reg[1];
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[5] <= work_reg[4];
            work_reg[6] <= work_reg[5];
            work_reg[7] <= work_reg[6];
        end
    end

    // Chaining value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= IV;
        end else if (cmd.restore) begin
            hash_reg <= IV;
        end else if (cmd.fold) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= hash_reg[i] + work_reg[i];
            end
        end
    end

    // Position within the block and message byte count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.shift_en) begin
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.restore) begin
                count_reg <= '0;
            end else if (cmd.count_inc) begin
                count_reg <= count_reg + 61'd1;
            end
        end
    end

    assign sts.pos     = pos_reg;
    assign digest_word = hash_reg[cmd.out_idx];

endmodule

`default_nettype wire

/* sv/sha256_control.sv */
`default_nettype none

module sha256_control import sha256_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    input  wire logic    s_tuser,
    input  wire logic    s_tlast,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    state_t     state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] idx_reg, idx_next;
    logic       end_pend_reg, end_pend_next;
    logic       len_ok_reg, len_ok_next;
    logic       final_reg, final_next;
    logic       pad_reg, pad_next;

    // State and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            round_reg    <= '0;
            idx_reg      <= '0;
            end_pend_reg <= 1'b0;
            len_ok_reg   <= 1'b0;
            final_reg    <= 1'b0;
            pad_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            idx_reg      <= idx_next;
            end_pend_reg <= end_pend_next;
            len_ok_reg   <= len_ok_next;
            final_reg    <= final_next;
            pad_reg      <= pad_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next    = state_reg;
        round_next    = round_reg;
        idx_next      = idx_reg;
        end_pend_next = end_pend_reg;
        len_ok_next   = len_ok_reg;
        final_next    = final_reg;
        pad_next      = pad_reg;
        cmd           = '0;
        cmd.byte_sel  = BYTE_IN;
        cmd.round_idx = round_reg;
        cmd.out_idx   = idx_reg;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        cmd.shift_en  = 1'b1;
                        cmd.count_inc = 1'b1;
                        if (sts.pos == LAST_POS) begin
                            // Block full: compress it before any padding.
                            cmd.init_work = 1'b1;
                            round_next    = '0;
                            end_pend_next = s_tlast;
                            state_next    = ST_ROUND;
                        end else if (s_tlast) begin
                            pad_next   = 1'b1;
                            state_next = ST_PAD_MARK;
                        end
                    end else if (s_tlast) begin
                        pad_next   = 1'b1;
                        state_next = ST_PAD_MARK;
                    end
                end
            end

            ST_PAD_MARK: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = BYTE_MARK;
                if (sts.pos == LAST_POS) begin
                    cmd.init_work = 1'b1;
                    round_next    = '0;
                    len_ok_next   = 1'b0;
                    final_next    = 1'b0;
                    state_next    = ST_ROUND;
                end else begin
                    // The length fits in this block only if the mark sits below it.
                    len_ok_next = (sts.pos < LEN_POS);
                    state_next  = ST_PAD_FILL;
                end
            end

            ST_PAD_FILL: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = (len_ok_reg && (sts.pos >= LEN_POS)) ? BYTE_LEN : BYTE_ZERO;
                if (sts.pos == LAST_POS) begin
                    cmd.init_work = 1'b1;
                    round_next    = '0;
                    final_next    = len_ok_reg;
                    state_next    = ST_ROUND;
                end
            end

            ST_ROUND: begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_FOLD;
                end
            end

            ST_FOLD: begin
                cmd.fold = 1'b1;
                priority if (final_reg) begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end else if (end_pend_reg) begin
                    end_pend_next = 1'b0;
                    pad_next      = 1'b1;
                    state_next    = ST_PAD_MARK;
                end else if (pad_reg) begin
                    // Extra padding block: zeros, then the length.
                    len_ok_next = 1'b1;
                    state_next  = ST_PAD_FILL;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (idx_reg == LAST_WORD_IDX) begin
                        cmd.restore   = 1'b1;
                        idx_next      = '0;
                        end_pend_next = 1'b0;
                        len_ok_next   = 1'b0;
                        final_next    = 1'b0;
                        pad_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tuser = idx_reg;
    assign m_tlast = (idx_reg == LAST_WORD_IDX);

endmodule

`default_nettype wire

/* sv/sha256_message_digest.sv */
`default_nettype none

// SHA-256 hash of a byte stream. Each input word carries one message byte in
// s_tdata when s_tuser is high, and s_tlast closes the message (a word with
// s_tuser low and s_tlast high ends the message without a byte, so an empty
// message hashes too). The block takes one byte per cycle until 64 have been
// gathered, then compresses them in 64 rounds of one shared round unit and
// a fold of the result into the chaining value; s_tready is low meanwhile.
// At the end of the message the padding is written into the block buffer
// one byte per cycle up to the end of the block (with a second compression
// and a further padding block when 56 or more bytes are pending), followed
// by the final compression. The eight digest words then
// leave on the master side, most significant first, with m_tuser giving the
// word position and m_tlast marking the eighth; the chaining value and byte
// count are restored for the next message as the last word is taken. Input
// and output are never active at the same time.
module sha256_message_digest import sha256_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] byte_present
    input  wire logic        s_tlast,   // end_of_message
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] digest_word
    output logic [2:0]       m_tuser,   // [2:0] word_index
    output logic             m_tlast    // last_word
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer for filling, padding, compression and output.
    sha256_control u_control (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Block buffer, round unit and chaining value.
    sha256_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .data_byte   (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .digest_word (m_tdata)
    );

endmodule

`default_nettype wire

/* sv/sha256_checker.sv */
`default_nettype none

module sha256_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    // Input is never taken while digest words are on offer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while digest words pending");

    // The tlast flag marks exactly the eighth word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
        else $error("tlast does not match word position");

    // Digest words follow one another without a gap, in order.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast)
        |=> (m_tvalid && (m_tuser == 3'($past(m_tuser) + 3'd1))))
        else $error("digest word sequence broken");

    // After the eighth word the output goes quiet.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output valid after last digest word");

    // A stalled word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled digest word changed");

endmodule

bind sha256_message_digest sha256_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
